// ===== rtl/core/word_ngram_span_extractor_defines.svh =====
// Assertion macros shared by the word n-gram span extractor RTL.
`ifndef WORD_NGRAM_SPAN_EXTRACTOR_DEFINES_SVH
`define WORD_NGRAM_SPAN_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define WNSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("word_ngram_span_extractor: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define WNSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("word_ngram_span_extractor: next-cycle check failed");

`endif

// ===== rtl/core/wnse_pkg.sv =====
// Types and constants of the word n-gram span extractor.
package wnse_pkg;

    localparam int OFFSET_W   = 24;
    localparam int WPG_W      = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_PERIOD = 8'h2E;

    // register index taken from paddr[2]
    localparam logic REG_WORDS_PER_GRAM = 1'b0;

    localparam logic [WPG_W-1:0] WPG_RESET = WPG_W'(1);

    typedef struct packed {
        logic [OFFSET_W-1:0] start_offset;
        logic [OFFSET_W-1:0] end_offset;
        logic                position_overflow;
    } t_span;

endpackage

// ===== rtl/core/word_ngram_span_extractor.sv =====
// Word n-gram span extractor: byte stream in, inclusive n-gram offsets out.
//
// Input channel: one beat per text byte (i_text_byte), or an end-of-text beat
// (i_end_of_text = 1) after the last byte. A beat is taken when i_in_valid and
// o_in_ready are both high. Output channel: one beat per n-gram span, taken
// when o_out_valid and i_out_ready are both high. Spaces, periods and the end
// beat close words; a period restarts the sentence; the end beat returns the
// window, byte position and overflow flag to their reset values.
// The gram size (words_per_gram) sits at APB byte address 0; write it only
// while the block is idle. pready is tied high.
// A closing beat registers its span into the output register, or into the
// skid register if the output is held. Throughput: one input beat per cycle
// while o_in_ready is high; window update and span compare finish on acceptance.
// Stall: an output register plus one skid register hold results; o_in_ready
// drops only once both are full and recovers the cycle after a beat leaves.
// Reset (synchronous, active low): empty output, position zero, one word held
// starting at offset zero, gram size one. No clearing pass is needed.
module word_ngram_span_extractor #(
    parameter int MAX_WINDOW    = 32,
    parameter int POSITION_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_text_byte,
    input  logic                                i_end_of_text,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [wnse_pkg::OFFSET_W-1:0]       o_start_offset,
    output logic [wnse_pkg::OFFSET_W-1:0]       o_end_offset,
    output logic                                o_position_overflow,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wnse_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wnse_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wnse_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import wnse_pkg::*;

    localparam int HW = $clog2(MAX_WINDOW);
    localparam int CW = (HW > WPG_W ? HW : WPG_W) + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [CW-1:0] WIN_TOP = CW'(MAX_WINDOW - 1);

    // state
    logic [WPG_W-1:0]         r_wpg;
    logic [POSITION_BITS-1:0] r_pos,  n_pos;
    logic [HW-1:0]            r_held, n_held;
    logic                     r_ovf,  n_ovf;
    logic [POSITION_BITS-1:0] r_ws_head, n_ws_head;
    logic [POSITION_BITS-1:0] r_ws_tail [1:MAX_WINDOW-1];
    logic [POSITION_BITS-1:0] n_ws      [0:MAX_WINDOW-1];
    logic [POSITION_BITS-1:0] w_ws      [0:MAX_WINDOW-1];

    // result staging
    logic  r_out_valid, r_skid_valid;
    t_span r_out, r_skid, w_span;

    logic                     w_accept, w_pop, w_push;
    logic                     w_space, w_period, w_boundary, w_slide;
    logic [POSITION_BITS-1:0] w_next_pos;
    logic [HW-1:0]            w_h, w_gram;
    logic [CW-1:0]            w_wpg_ext, w_held_ext;

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pop      = r_out_valid && i_out_ready;

    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(r_wpg);

    always_comb begin
        w_ws[0] = r_ws_head;
        for (int i = 1; i < MAX_WINDOW; i++) begin
            w_ws[i] = r_ws_tail[i];
        end
    end

    assign w_space    = !i_end_of_text && (i_text_byte == CHAR_SPACE);
    assign w_period   = !i_end_of_text && (i_text_byte == CHAR_PERIOD);
    assign w_boundary = i_end_of_text || w_space || w_period;
    assign w_next_pos = (r_pos == POS_MAX) ? r_pos : r_pos + POSITION_BITS'(1);

    // clamp gram size to 1 .. MAX_WINDOW-1; held count is already in range
    assign w_wpg_ext  = CW'(r_wpg);
    assign w_held_ext = CW'(r_held);
    always_comb begin
        priority if (r_wpg == '0) begin
            w_gram = HW'(1);
        end else if (w_wpg_ext > WIN_TOP) begin
            w_gram = HW'(MAX_WINDOW - 1);
        end else begin
            w_gram = HW'(r_wpg);
        end
        w_h = (w_held_ext > WIN_TOP) ? HW'(MAX_WINDOW - 1) : r_held;
    end

    assign w_slide = w_h >= w_gram;
    assign w_push  = w_accept && w_boundary && w_slide && (r_pos > r_ws_head);

    assign w_span.start_offset      = OFFSET_W'(r_ws_head);
    assign w_span.end_offset        = OFFSET_W'(r_pos - POSITION_BITS'(1));
    assign w_span.position_overflow = r_ovf;

    // window, count, position update for one beat
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            n_ws[i] = w_ws[i];
        end
        n_held = r_held;
        n_pos  = r_pos;
        n_ovf  = r_ovf;
        if (w_boundary) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                if (HW'(i) == w_h) begin
                    n_ws[i] = w_next_pos;
                end else if (w_slide && HW'(i) < w_h) begin
                    if (HW'(i) == w_h - HW'(1)) begin
                        n_ws[i] = w_next_pos;
                    end else if (i < MAX_WINDOW - 1) begin
                        n_ws[i] = w_ws[(i + 1) % MAX_WINDOW];
                    end
                end
            end
            n_held = w_slide ? w_h : w_h + HW'(1);
            if (w_period) begin
                n_ws[0] = w_next_pos;
                n_held  = HW'(1);
            end
        end
        if (i_end_of_text) begin
            n_ws[0] = '0;
            n_held  = HW'(1);
            n_pos   = '0;
            n_ovf   = 1'b0;
        end else if (r_pos == POS_MAX) begin
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + POSITION_BITS'(1);
        end
    end
    assign n_ws_head = n_ws[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpg        <= WPG_RESET;
            r_pos        <= '0;
            r_held       <= HW'(1);
            r_ovf        <= 1'b0;
            r_ws_head    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_WORDS_PER_GRAM) begin
                r_wpg <= pwdata[WPG_W-1:0];
            end
            if (w_accept) begin
                r_pos     <= n_pos;
                r_held    <= n_held;
                r_ovf     <= n_ovf;
                r_ws_head <= n_ws_head;
            end
            if (!r_out_valid || w_pop) begin
                // refill from skid first, else take the new span
                r_out_valid  <= r_skid_valid || w_push;
                r_skid_valid <= 1'b0;
            end else if (w_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 1; i < MAX_WINDOW; i++) begin
                r_ws_tail[i] <= n_ws[i];
            end
        end
        if (!r_out_valid || w_pop) begin
            r_out <= r_skid_valid ? r_skid : w_span;
        end else if (w_push) begin
            r_skid <= w_span;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_start_offset      = r_out.start_offset;
    assign o_end_offset        = r_out.end_offset;
    assign o_position_overflow = r_out.position_overflow;

`include "word_ngram_span_extractor_defines.svh"

    `WNSE_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `WNSE_ASSERT_IMPL(a_held_nonzero, i_clk, i_rst_n, 1'b1, r_held != '0)
    `WNSE_ASSERT_IMPL(a_ovf_at_max, i_clk, i_rst_n, r_ovf, r_pos == POS_MAX)
    `WNSE_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, w_accept && i_end_of_text,
        r_pos == '0 && r_held == HW'(1) && !r_ovf && r_ws_head == '0)

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the word n-gram span extractor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wnse_pkg::*;

    localparam int unsigned MAX_WINDOW = 32;
    localparam logic [OFFSET_W-1:0] POS_MAX = '1;
    localparam logic [APB_ADDR_W-1:0] WPG_ADDR = {REG_WORDS_PER_GRAM, 2'b00};
    localparam int unsigned NUM_PHASES = 12;
    localparam int unsigned PRESSURE_PHASE = 6;
    localparam int unsigned RANDOM_SIZE_PHASE = 8;
    localparam int unsigned LONG_HOLD = 300;

    typedef enum int unsigned {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_e;

    // Tracks the window of word starts and queues the spans it must produce.
    class ngram_span_predictor;
        logic [OFFSET_W-1:0] word_start [MAX_WINDOW];
        int unsigned         words_held;
        logic [OFFSET_W-1:0] byte_pos;
        logic                overflow_seen;
        logic [WPG_W-1:0]    gram_size;
        t_span               expected_spans [$];
        int unsigned         mismatches;

        function new();
            gram_size  = WPG_RESET;
            mismatches = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (word_start[i]) word_start[i] = '0;
            words_held    = 1;
            byte_pos      = '0;
            overflow_seen = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_spans.size();
        endfunction

        function void note_beat(logic [7:0] ch, logic last);
            logic                is_period;
            logic                closes;
            int unsigned         n;
            int unsigned         h;
            logic [OFFSET_W-1:0] p;
            logic [OFFSET_W-1:0] nxt;
            t_span               span;
            is_period = !last && ch == CHAR_PERIOD;
            closes    = last || is_period || ch == CHAR_SPACE;
            p         = byte_pos;
            nxt       = (p == POS_MAX) ? p : p + 1'b1;
            n         = (gram_size == 0) ? 1 : gram_size;
            if (n > MAX_WINDOW - 1) n = MAX_WINDOW - 1;
            if (closes) begin
                h = (words_held > MAX_WINDOW - 1) ? MAX_WINDOW - 1 : words_held;
                word_start[h] = nxt;
                if (h >= n) begin
                    // an empty span (back-to-back separators) yields nothing
                    if (p > word_start[0]) begin
                        span.start_offset      = word_start[0];
                        span.end_offset        = p - 1'b1;
                        span.position_overflow = overflow_seen;
                        expected_spans.push_back(span);
                    end
                    for (int i = 0; i < h; i++) word_start[i] = word_start[i + 1];
                    words_held = h;
                end else begin
                    words_held = h + 1;
                end
                if (is_period) begin
                    word_start[0] = nxt;
                    words_held    = 1;
                end
            end
            if (last) begin
                clear_text();
            end else if (p == POS_MAX) begin
                overflow_seen = 1'b1;
            end else begin
                byte_pos = p + 1'b1;
            end
        endfunction

        function void check_span(logic [OFFSET_W-1:0] start_off, logic [OFFSET_W-1:0] end_off,
                                 logic ovf);
            t_span want;
            if (expected_spans.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected span, expected none, actual start %0d end %0d ovf %0b",
                         $time, start_off, end_off, ovf);
                return;
            end
            want = expected_spans.pop_front();
            if (start_off !== want.start_offset) begin
                mismatches++;
                $display("%0t: start_offset expected %0d actual %0d",
                         $time, want.start_offset, start_off);
            end
            if (end_off !== want.end_offset) begin
                mismatches++;
                $display("%0t: end_offset expected %0d actual %0d",
                         $time, want.end_offset, end_off);
            end
            if (ovf !== want.position_overflow) begin
                mismatches++;
                $display("%0t: position_overflow expected %0b actual %0b",
                         $time, want.position_overflow, ovf);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_text_byte = '0;
    logic                  i_end_of_text = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [OFFSET_W-1:0]   o_start_offset;
    logic [OFFSET_W-1:0]   o_end_offset;
    logic                  o_position_overflow;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ngram_span_predictor sb = new();
    idle_mode_e          tx_mode = IDLE_SPARSE;
    idle_mode_e          rx_mode = IDLE_SPARSE;
    int unsigned         rx_hold = 0;
    int unsigned         beats_sent = 0;

    word_ngram_span_extractor i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_text_byte        (i_text_byte),
        .i_end_of_text      (i_end_of_text),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_start_offset     (o_start_offset),
        .o_end_offset       (o_end_offset),
        .o_position_overflow(o_position_overflow),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned draw_gap(idle_mode_e mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            default:     return $urandom_range(0, 17);
        endcase
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) != 0) return 8'h61 + 8'($urandom_range(0, 25));
        b = 8'($urandom_range(0, 255));
        // keep separators out of the word body
        return (b == CHAR_SPACE || b == CHAR_PERIOD) ? 8'h5F : b;
    endfunction

    task automatic send_beat(input logic [7:0] ch, input logic last);
        int unsigned gap;
        gap = draw_gap(tx_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= ch;
        i_end_of_text <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_beat(ch, last);
        beats_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // let a beat that closes no span settle before touching the register
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.gram_size = data[WPG_W-1:0];
    endtask

    task automatic send_sentence(input int unsigned words);
        for (int unsigned w = 0; w < words; w++) begin
            repeat ($urandom_range(1, 4)) send_beat(word_byte(), 1'b0);
            if (w == words - 1 && $urandom_range(0, 3) != 0) begin
                send_beat(CHAR_PERIOD, 1'b0);
                if ($urandom_range(0, 1)) send_beat(CHAR_SPACE, 1'b0);
            end else begin
                repeat (($urandom_range(0, 7) == 0) ? 2 : 1) send_beat(CHAR_SPACE, 1'b0);
            end
        end
    endtask

    // Mostly whole sentences sized around the gram size, some noise and early ends.
    task automatic send_text(input int unsigned budget);
        int unsigned target;
        int unsigned n;
        target = beats_sent + budget;
        n      = (sb.gram_size == 0) ? 1 : sb.gram_size;
        while (beats_sent < target) begin
            case ($urandom_range(0, 19))
                0: send_beat(8'($urandom_range(0, 255)), 1'b1);
                1: repeat ($urandom_range(1, 6))
                       send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                default: begin
                    if ($urandom_range(0, 3) == 0) send_sentence($urandom_range(1, n));
                    else send_sentence(n + $urandom_range(0, 6));
                end
            endcase
        end
    endtask

    initial begin : receiver
        int unsigned stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall   = (rx_hold > 0) ? rx_hold : draw_gap(rx_mode);
            rx_hold = 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_span(o_start_offset, o_end_offset, o_position_overflow);
        end
    end

    initial begin : stimulus
        logic [APB_DATA_W-1:0] phase_cfg [NUM_PHASES];
        logic [APB_DATA_W-1:0] cfg;
        int unsigned           n;
        phase_cfg = '{32'hFFFF_FFFF, 1, 2, 0, 3, 17, 1, 4, 0, 7, 2, 5};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extreme bytes, empty span after double space, period, end item
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CHAR_SPACE, 1'b0);
        send_beat(CHAR_SPACE, 1'b0);
        send_beat(8'h61, 1'b0);
        send_beat(CHAR_PERIOD, 1'b0);
        send_beat(CHAR_PERIOD, 1'b1);
        // gram size zero acts as one
        wait_drained();
        apb_write(WPG_ADDR, '0);
        send_string("x y");
        send_beat(8'h00, 1'b1);
        // fill four words, then lower the size mid-text
        wait_drained();
        apb_write(WPG_ADDR, 4);
        send_string("ab c d ");
        wait_drained();
        apb_write(WPG_ADDR, 2);
        send_string("e ");
        send_beat(CHAR_SPACE, 1'b1);

        for (int unsigned k = 0; k < NUM_PHASES; k++) begin
            wait_drained();
            cfg = (k == RANDOM_SIZE_PHASE) ? APB_DATA_W'($urandom_range(1, 31)) : phase_cfg[k];
            apb_write(WPG_ADDR, cfg);
            n       = (sb.gram_size == 0) ? 1 : sb.gram_size;
            tx_mode = idle_mode_e'($urandom_range(0, 2));
            rx_mode = idle_mode_e'($urandom_range(0, 2));
            if (k == PRESSURE_PHASE) begin
                // stall the output long enough to back up the input
                tx_mode = IDLE_NONE;
                rx_hold = LONG_HOLD;
                send_text(60);
                wait_drained();
                send_text(60);
            end else begin
                send_text(60 + 8 * n);
            end
            if ($urandom_range(0, 1)) send_beat(8'($urandom_range(0, 255)), 1'b1);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0t: %0d expected spans never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("%0t: timeout with %0d spans outstanding", $time, sb.pending());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/wnse_pkg.sv
rtl/core/word_ngram_span_extractor.sv
bench/testbench.sv
